/* sv/bpc_pkg.sv */
// shared types and constants for the button press classifier
`default_nettype none

package bpc_pkg;

   // configuration register file
   localparam int unsigned REG_BITS      = 11;
   localparam int unsigned CSR_ADDR_BITS = 5;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_MIN    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_LONG_THRESHOLD = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_REPEAT_RELOAD  = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_HOLD_CLAMP     = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_LONG_MAX       = 3'd4;

   localparam logic [REG_BITS-1:0] RELEASE_MIN_RST    = 11'd100;
   localparam logic [REG_BITS-1:0] LONG_THRESHOLD_RST = 11'd1000;
   localparam logic [REG_BITS-1:0] REPEAT_RELOAD_RST  = 11'd950;
   localparam logic [REG_BITS-1:0] HOLD_CLAMP_RST     = 11'd1050;
   localparam logic [REG_BITS-1:0] LONG_MAX_RST       = 11'd2000;

   // sticky flag positions, same order as the acknowledge mask
   localparam int unsigned FLAG_BITS    = 7;
   localparam int unsigned F_INC        = 0;
   localparam int unsigned F_DEC        = 1;
   localparam int unsigned F_SET_SHORT  = 2;
   localparam int unsigned F_SET_LONG   = 3;
   localparam int unsigned F_ENT_SHORT  = 4;
   localparam int unsigned F_ENT_LONG   = 5;
   localparam int unsigned F_COMBO      = 6;

   typedef struct packed {
      logic                 inc_level;
      logic                 dec_level;
      logic                 set_level;
      logic                 enter_level;
      logic                 combo_level;
      logic [FLAG_BITS-1:0] ack_mask;
   } req_type;

   typedef struct packed {
      logic inc_flag;
      logic dec_flag;
      logic set_short;
      logic set_long;
      logic enter_short;
      logic enter_long;
      logic combo_flag;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/button_press_classifier_top.sv */
// button press classifier: tick-driven short/long press detection with sticky flags
// an accepted tick's result is registered once the result slot is free or draining
// throughput: one tick per cycle while rsp_ready is high; the per-tick update is a
// single registered pass over five hold counters and the flag register, limited by
// one compare chain. reset (synchronous, active high) clears counters, flags and both
// pipeline valids, and loads the configuration registers with their defaults
`default_nettype none

module button_press_classifier_top #(
   parameter int unsigned COUNT_BITS = 11
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // tick channel
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire bpc_pkg::req_type                       req_payload,
   // flag channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output bpc_pkg::rsp_type                            rsp_payload,
   // configuration port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [bpc_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  wire logic [bpc_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [bpc_pkg::CSR_DATA_BITS-1:0]           csr_prdata,
   output logic                                        csr_pready
);

   // compares run at the wider of counter and register width
   localparam int unsigned CMP_BITS =
      (COUNT_BITS > bpc_pkg::REG_BITS) ? COUNT_BITS : bpc_pkg::REG_BITS;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [bpc_pkg::REG_BITS-1:0]     release_min_ff;
   logic [bpc_pkg::REG_BITS-1:0]     long_threshold_ff;
   logic [bpc_pkg::REG_BITS-1:0]     repeat_reload_ff;
   logic [bpc_pkg::REG_BITS-1:0]     hold_clamp_ff;
   logic [bpc_pkg::REG_BITS-1:0]     long_max_ff;
   logic                             csr_write;
   logic [bpc_pkg::REG_IDX_BITS-1:0] csr_index;
   logic [bpc_pkg::REG_BITS-1:0]     csr_wval;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // registers sit on word addresses, byte offset ignored
   assign csr_index  = csr_paddr[bpc_pkg::CSR_ADDR_BITS-1:2];
   assign csr_wval   = csr_pwdata[bpc_pkg::REG_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         release_min_ff    <= bpc_pkg::RELEASE_MIN_RST;
         long_threshold_ff <= bpc_pkg::LONG_THRESHOLD_RST;
         repeat_reload_ff  <= bpc_pkg::REPEAT_RELOAD_RST;
         hold_clamp_ff     <= bpc_pkg::HOLD_CLAMP_RST;
         long_max_ff       <= bpc_pkg::LONG_MAX_RST;
      end else if (csr_write) begin
         // writes beyond the register list are dropped
         unique case (csr_index)
            bpc_pkg::REG_RELEASE_MIN:    release_min_ff    <= csr_wval;
            bpc_pkg::REG_LONG_THRESHOLD: long_threshold_ff <= csr_wval;
            bpc_pkg::REG_REPEAT_RELOAD:  repeat_reload_ff  <= csr_wval;
            bpc_pkg::REG_HOLD_CLAMP:     hold_clamp_ff     <= csr_wval;
            bpc_pkg::REG_LONG_MAX:       long_max_ff       <= csr_wval;
            default: ;
         endcase
      end
   end

   // read-back, zero outside the register list
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         bpc_pkg::REG_RELEASE_MIN:
            csr_prdata = bpc_pkg::CSR_DATA_BITS'(release_min_ff);
         bpc_pkg::REG_LONG_THRESHOLD:
            csr_prdata = bpc_pkg::CSR_DATA_BITS'(long_threshold_ff);
         bpc_pkg::REG_REPEAT_RELOAD:
            csr_prdata = bpc_pkg::CSR_DATA_BITS'(repeat_reload_ff);
         bpc_pkg::REG_HOLD_CLAMP:
            csr_prdata = bpc_pkg::CSR_DATA_BITS'(hold_clamp_ff);
         bpc_pkg::REG_LONG_MAX:
            csr_prdata = bpc_pkg::CSR_DATA_BITS'(long_max_ff);
         default: csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // pipeline control: input register -> update pass -> result register
   // ---------------------------------------------------------------------
   logic             in_valid_ff;
   bpc_pkg::req_type in_payload_ff;
   logic             rsp_valid_ff;
   bpc_pkg::rsp_type rsp_payload_ff;
   logic             advance;

   // the held tick moves on when the result slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   // input register takes a new transfer whenever it is empty or emptying
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_payload_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------------
   // hold counters and sticky flags
   // ---------------------------------------------------------------------
   logic [COUNT_BITS-1:0]         inc_count_ff,   inc_count_in;
   logic [COUNT_BITS-1:0]         dec_count_ff,   dec_count_in;
   logic [COUNT_BITS-1:0]         set_count_ff,   set_count_in;
   logic [COUNT_BITS-1:0]         enter_count_ff, enter_count_in;
   logic [COUNT_BITS-1:0]         combo_count_ff, combo_count_in;
   logic [bpc_pkg::FLAG_BITS-1:0] event_flags_ff, event_flags_in;

   logic [CMP_BITS-1:0]   rel_min_w;
   logic [CMP_BITS-1:0]   long_thr_w;
   logic [CMP_BITS-1:0]   reload_w;
   logic [CMP_BITS-1:0]   clamp_w;
   logic [CMP_BITS-1:0]   long_max_w;
   logic [COUNT_BITS-1:0] reload_sat;

   // saturating advance by one
   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (c == CMAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [CMP_BITS-1:0] widen(input logic [COUNT_BITS-1:0] c);
      return CMP_BITS'(c);
   endfunction

   assign rel_min_w  = CMP_BITS'(release_min_ff);
   assign long_thr_w = CMP_BITS'(long_threshold_ff);
   assign reload_w   = CMP_BITS'(repeat_reload_ff);
   assign clamp_w    = CMP_BITS'(hold_clamp_ff);
   assign long_max_w = CMP_BITS'(long_max_ff);
   // auto-repeat reload cannot exceed what the counter holds
   assign reload_sat = (reload_w > widen(CMAX)) ? CMAX : COUNT_BITS'(repeat_reload_ff);

   always_comb begin
      // acknowledged flags drop before the tick is evaluated
      event_flags_in = event_flags_ff & ~in_payload_ff.ack_mask;
      inc_count_in   = inc_count_ff;
      dec_count_in   = dec_count_ff;
      set_count_in   = set_count_ff;
      enter_count_in = enter_count_ff;
      combo_count_in = combo_count_ff;

      // only the highest priority pressed button advances its counter
      priority if (in_payload_ff.inc_level) begin
         inc_count_in = bump(inc_count_in);
      end else if (in_payload_ff.dec_level) begin
         dec_count_in = bump(dec_count_in);
      end else if (in_payload_ff.combo_level) begin
         set_count_in   = '0;
         enter_count_in = '0;
         combo_count_in = bump(combo_count_in);
      end else if (in_payload_ff.set_level) begin
         set_count_in = bump(set_count_in);
      end else if (in_payload_ff.enter_level) begin
         enter_count_in = bump(enter_count_in);
      end else begin
         // no button pressed, every counter holds
      end

      // increment: auto-repeat while held long, flag on a valid release
      if (in_payload_ff.inc_level) begin
         if (widen(inc_count_in) > long_thr_w) begin
            event_flags_in[bpc_pkg::F_INC] = 1'b1;
            inc_count_in = reload_sat;
         end
      end else begin
         if (widen(inc_count_in) > rel_min_w) begin
            event_flags_in[bpc_pkg::F_INC] = 1'b1;
         end
         inc_count_in = '0;
      end

      // decrement: same scheme as increment
      if (in_payload_ff.dec_level) begin
         if (widen(dec_count_in) > long_thr_w) begin
            event_flags_in[bpc_pkg::F_DEC] = 1'b1;
            dec_count_in = reload_sat;
         end
      end else begin
         if (widen(dec_count_in) > rel_min_w) begin
            event_flags_in[bpc_pkg::F_DEC] = 1'b1;
         end
         dec_count_in = '0;
      end

      // set: clamp while held, classify short or long on release
      if (in_payload_ff.set_level) begin
         if (widen(set_count_in) > clamp_w) begin
            set_count_in = COUNT_BITS'(hold_clamp_ff);
         end
      end else begin
         if (widen(set_count_in) > rel_min_w && widen(set_count_in) <= long_thr_w) begin
            event_flags_in[bpc_pkg::F_SET_SHORT] = 1'b1;
            event_flags_in[bpc_pkg::F_SET_LONG]  = 1'b0;
         end else if (widen(set_count_in) > long_thr_w
                      && widen(set_count_in) <= long_max_w) begin
            event_flags_in[bpc_pkg::F_SET_SHORT] = 1'b0;
            event_flags_in[bpc_pkg::F_SET_LONG]  = 1'b1;
         end
         set_count_in = '0;
      end

      // enter: same scheme as set
      if (in_payload_ff.enter_level) begin
         if (widen(enter_count_in) > clamp_w) begin
            enter_count_in = COUNT_BITS'(hold_clamp_ff);
         end
      end else begin
         if (widen(enter_count_in) > rel_min_w
             && widen(enter_count_in) <= long_thr_w) begin
            event_flags_in[bpc_pkg::F_ENT_SHORT] = 1'b1;
            event_flags_in[bpc_pkg::F_ENT_LONG]  = 1'b0;
         end else if (widen(enter_count_in) > long_thr_w
                      && widen(enter_count_in) <= long_max_w) begin
            event_flags_in[bpc_pkg::F_ENT_SHORT] = 1'b0;
            event_flags_in[bpc_pkg::F_ENT_LONG]  = 1'b1;
         end
         enter_count_in = '0;
      end

      // combo: holds set and enter at zero, reports a long hold on release
      if (in_payload_ff.combo_level) begin
         set_count_in   = '0;
         enter_count_in = '0;
         if (widen(combo_count_in) > long_thr_w) begin
            combo_count_in = COUNT_BITS'(long_threshold_ff);
         end
      end else begin
         if (widen(combo_count_in) >= long_thr_w) begin
            event_flags_in[bpc_pkg::F_COMBO] = 1'b1;
         end
         combo_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_count_ff   <= '0;
         dec_count_ff   <= '0;
         set_count_ff   <= '0;
         enter_count_ff <= '0;
         combo_count_ff <= '0;
         event_flags_ff <= '0;
      end else if (advance) begin
         inc_count_ff   <= inc_count_in;
         dec_count_ff   <= dec_count_in;
         set_count_ff   <= set_count_in;
         enter_count_ff <= enter_count_in;
         combo_count_ff <= combo_count_in;
         event_flags_ff <= event_flags_in;
      end
   end

   // result register takes the updated flags with each tick
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.inc_flag    <= event_flags_in[bpc_pkg::F_INC];
         rsp_payload_ff.dec_flag    <= event_flags_in[bpc_pkg::F_DEC];
         rsp_payload_ff.set_short   <= event_flags_in[bpc_pkg::F_SET_SHORT];
         rsp_payload_ff.set_long    <= event_flags_in[bpc_pkg::F_SET_LONG];
         rsp_payload_ff.enter_short <= event_flags_in[bpc_pkg::F_ENT_SHORT];
         rsp_payload_ff.enter_long  <= event_flags_in[bpc_pkg::F_ENT_LONG];
         rsp_payload_ff.combo_flag  <= event_flags_in[bpc_pkg::F_COMBO];
      end
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // a combo tick leaves set and enter counters at zero
   a_combo_zeroes: assert property (@(posedge clock) disable iff (reset)
      (advance && in_payload_ff.combo_level)
         |=> (set_count_ff == '0 && enter_count_ff == '0))
      else $error("set/enter counter not zero after combo tick");

   // a released increment button leaves its counter at zero
   a_inc_release: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_payload_ff.inc_level) |=> (inc_count_ff == '0))
      else $error("increment counter not cleared on release");

   // short and long of one button never pend together
   a_set_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(event_flags_ff[bpc_pkg::F_SET_SHORT] && event_flags_ff[bpc_pkg::F_SET_LONG]))
      else $error("set short and long both pending");

   a_ent_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(event_flags_ff[bpc_pkg::F_ENT_SHORT] && event_flags_ff[bpc_pkg::F_ENT_LONG]))
      else $error("enter short and long both pending");

   // a shown result's combo and increment flags match the flag state it came from
   a_rsp_tracks_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.combo_flag == event_flags_ff[bpc_pkg::F_COMBO]
                        && rsp_payload_ff.inc_flag == event_flags_ff[bpc_pkg::F_INC]))
      else $error("result payload diverged from flag state");

endmodule

`default_nettype wire
